>>> hw/rtl/kdlp_pkg.sv
`timescale 1ns / 1ps

package kdlp_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TIME   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_TIME = 2'd1;

   localparam logic [15:0] DEBOUNCE_TIME_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_TIME_RESET = 16'd1000;

   // Action codes
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_INIT   = 2'd2;

   // Event codes
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_PRESS   = 3'd1;
   localparam logic [2:0] EV_CLICK   = 3'd2;
   localparam logic [2:0] EV_RELEASE = 3'd3;
   localparam logic [2:0] EV_LONG    = 3'd4;

   typedef struct packed {
      logic [1:0]  action;
      logic        raw_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       pressed;
      logic [2:0] event_res;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_time_ms;
      logic [15:0] long_press_time_ms;
   } cfg_type;

endpackage

>>> hw/rtl/kdlp_csr.sv
`timescale 1ns / 1ps

module kdlp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kdlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kdlp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output kdlp_pkg::cfg_type                 cfg
);
   import kdlp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // always able to take a write
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME:   cfg_in.debounce_time_ms   = csr_wdata;
            CSR_LONG_PRESS_TIME: cfg_in.long_press_time_ms = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time_ms   <= DEBOUNCE_TIME_RESET;
         cfg_ff.long_press_time_ms <= LONG_PRESS_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/kdlp_core.sv
`timescale 1ns / 1ps

module kdlp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  kdlp_pkg::req_type item,
   input  kdlp_pkg::cfg_type cfg,
   output kdlp_pkg::rsp_type result
);
   import kdlp_pkg::*;

   logic        stable_level_ff, stable_level_in;
   logic        pressed_level_ff, pressed_level_in;
   logic        long_latched_ff, long_latched_in;
   logic [31:0] last_agree_time_ff, last_agree_time_in;
   logic [31:0] press_start_time_ff, press_start_time_in;
   logic [2:0]  pending_event_ff, pending_event_in;

   logic [31:0] agree_elapsed;
   logic [31:0] held_elapsed;
   logic        level_differs;
   logic        accept_change;
   logic        press_accepted;
   logic        long_hit;
   logic [2:0]  ev;

   // elapsed times, wrapping
   assign agree_elapsed  = item.now_ms - last_agree_time_ff;
   assign held_elapsed   = item.now_ms - press_start_time_ff;
   assign level_differs  = item.raw_level != stable_level_ff;
   assign accept_change  = level_differs && (agree_elapsed >= {16'd0, cfg.debounce_time_ms});
   assign press_accepted = accept_change && item.raw_level;

   always_comb begin
      stable_level_in     = stable_level_ff;
      pressed_level_in    = pressed_level_ff;
      long_latched_in     = long_latched_ff;
      last_agree_time_in  = last_agree_time_ff;
      press_start_time_in = press_start_time_ff;
      pending_event_in    = pending_event_ff;
      long_hit            = 1'b0;
      ev                  = EV_NONE;

      unique case (item.action)
         ACT_SAMPLE: begin
            // debounce step
            if (level_differs) begin
               if (accept_change) begin
                  stable_level_in    = item.raw_level;
                  last_agree_time_in = item.now_ms;
                  if (item.raw_level) begin
                     pressed_level_in    = 1'b1;
                     press_start_time_in = item.now_ms;
                     long_latched_in     = 1'b0;
                     pending_event_in    = EV_PRESS;
                  end else begin
                     pressed_level_in = 1'b0;
                     pending_event_in = long_latched_ff ? EV_RELEASE : EV_CLICK;
                  end
               end
            end else begin
               last_agree_time_in = item.now_ms;
            end
            // long-press test; a fresh press has zero held time, a release ends the hold
            if (press_accepted) begin
               long_hit = (cfg.long_press_time_ms == 16'd0);
            end else begin
               long_hit = pressed_level_in && !long_latched_in &&
                          (held_elapsed >= {16'd0, cfg.long_press_time_ms});
            end
            if (long_hit) begin
               long_latched_in  = 1'b1;
               pending_event_in = EV_LONG;
            end
         end
         ACT_READ: begin
            ev               = pending_event_ff;
            pending_event_in = EV_NONE;
         end
         ACT_INIT: begin
            stable_level_in     = item.raw_level;
            pressed_level_in    = item.raw_level;
            long_latched_in     = 1'b0;
            last_agree_time_in  = item.now_ms;
            press_start_time_in = item.now_ms;
            pending_event_in    = EV_NONE;
         end
         default: begin
            ev = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff     <= 1'b0;
         pressed_level_ff    <= 1'b0;
         long_latched_ff     <= 1'b0;
         last_agree_time_ff  <= '0;
         press_start_time_ff <= '0;
         pending_event_ff    <= EV_NONE;
      end else if (fire) begin
         stable_level_ff     <= stable_level_in;
         pressed_level_ff    <= pressed_level_in;
         long_latched_ff     <= long_latched_in;
         last_agree_time_ff  <= last_agree_time_in;
         press_start_time_ff <= press_start_time_in;
         pending_event_ff    <= pending_event_in;
      end
   end

   assign result.pressed   = pressed_level_in;
   assign result.event_res = ev;

endmodule

>>> hw/rtl/key_debounce_long_press_unit.sv
`timescale 1ns / 1ps
// Key debounce and long-press detector.
// An accepted req word goes through the input register, then the state update
// into the result register, to become its rsp word.
// Throughput: one word per cycle while rsp_stall does not hold the result word.
// Reset: synchronous; clears all key state and pending event, timing registers
// return to 20 ms debounce and 1000 ms long press.
module key_debounce_long_press_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kdlp_pkg::req_type                 req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kdlp_pkg::rsp_type                 rsp_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kdlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [kdlp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kdlp_pkg::*;

   cfg_type cfg;
   req_type in_word_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_word_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type result;
   logic    req_take;
   logic    advance;

   kdlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kdlp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   // handshake control
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a stall on the request side only comes with a held word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held word");

   // a processed word shows up as a result next cycle
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed word lost");

   // event codes stay in the defined range
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.event_res <= EV_LONG))
      else $error("undefined event code");

   // a stalled word on the input side is held, not replaced
   a_held_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> $stable(in_word_ff))
      else $error("held input word changed");

endmodule

>>> bench/tb_key_debounce_long_press_unit.sv
`timescale 1ns / 1ps

module tb_key_debounce_long_press_unit;
   import kdlp_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         IDLE_PCT    = 36;
   localparam int         HOLD_CYCLES = 400;
   localparam int         QUIET_LIMIT = 4000;
   localparam int         PHASE_WORDS = 185;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // words waiting to be sent, results waiting to arrive
   req_type word_q[$];
   rsp_type result_q[$];

   // predicted key state and timing settings
   logic        key_stable;
   logic        key_pressed;
   logic        key_long;
   logic [31:0] agree_ms;
   logic [31:0] press_ms;
   logic [2:0]  key_event;
   logic [15:0] debounce_ms;
   logic [15:0] long_ms;

   // random stimulus state
   logic [31:0] gen_ms;
   logic        gen_level;

   // run control
   logic no_idle     = 1'b0;
   int   hold_asks   = 0;
   int   hold_served = 0;
   int   hold_left   = 0;
   int   fail_count  = 0;
   int   words_sent  = 0;
   int   results_checked = 0;
   int   settings_used   = 0;
   int   quiet_cycles    = 0;

   key_debounce_long_press_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // next debounced level and event for one accepted word
   function automatic rsp_type debounce_predict(input req_type w);
      rsp_type     r;
      logic [2:0]  ev;
      logic [31:0] since_agree;
      logic [31:0] since_press;
      ev = EV_NONE;
      case (w.action)
         ACT_SAMPLE: begin
            since_agree = w.now_ms - agree_ms;
            if (w.raw_level != key_stable) begin
               if (since_agree >= {16'd0, debounce_ms}) begin
                  key_stable = w.raw_level;
                  agree_ms   = w.now_ms;
                  if (w.raw_level) begin
                     key_pressed = 1'b1;
                     press_ms    = w.now_ms;
                     key_long    = 1'b0;
                     key_event   = EV_PRESS;
                  end else begin
                     key_pressed = 1'b0;
                     key_event   = key_long ? EV_RELEASE : EV_CLICK;
                  end
               end
            end else begin
               agree_ms = w.now_ms;
            end
            // long-press test also runs right after a press is taken
            since_press = w.now_ms - press_ms;
            if (key_pressed && !key_long && since_press >= {16'd0, long_ms}) begin
               key_long  = 1'b1;
               key_event = EV_LONG;
            end
         end
         ACT_READ: begin
            ev        = key_event;
            key_event = EV_NONE;
         end
         ACT_INIT: begin
            key_stable  = w.raw_level;
            key_pressed = w.raw_level;
            key_long    = 1'b0;
            agree_ms    = w.now_ms;
            press_ms    = w.now_ms;
            key_event   = EV_NONE;
         end
         default: begin
         end
      endcase
      r.pressed   = key_pressed;
      r.event_res = ev;
      return r;
   endfunction

   // sender: present queued words, hold a stalled word
   always @(posedge clock) begin : driver
      logic idle_now;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            result_q.push_back(debounce_predict(word_q.pop_front()));
            words_sent++;
         end
         idle_now = !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
         if (req_valid && req_stall) begin
            // keep the stalled word on the bus
         end else if (word_q.size() != 0 && !idle_now) begin
            req_valid <= 1'b1;
            req_word  <= word_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: check each result word, random stall plus long hold-off on request
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("unexpected result word: pressed %0d event_res %0d",
                      rsp_word.pressed, rsp_word.event_res);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_word.pressed !== want.pressed) begin
                  $error("pressed: expected %0d, actual %0d", want.pressed, rsp_word.pressed);
                  fail_count++;
               end
               if (rsp_word.event_res !== want.event_res) begin
                  $error("event_res: expected %0d, actual %0d",
                         want.event_res, rsp_word.event_res);
                  fail_count++;
               end
               results_checked++;
            end
         end
         if (hold_asks != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // end the run if no word moves on any channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic push_word(input logic [1:0] act, input logic lvl, input logic [31:0] t);
      req_type w;
      w.action    = act;
      w.raw_level = lvl;
      w.now_ms    = t;
      word_q.push_back(w);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DEBOUNCE_TIME) begin
         debounce_ms = val;
      end else begin
         long_ms = val;
      end
   endtask

   task automatic set_timing(input logic [15:0] deb, input logic [15:0] lng);
      write_csr(CSR_DEBOUNCE_TIME, deb);
      write_csr(CSR_LONG_PRESS_TIME, lng);
      settings_used++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (word_q.size() != 0 || req_valid || result_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // mostly bouncy press/release samples on a running clock, some reads,
   // re-inits, unused actions and time jumps
   task automatic fill_random(input int count);
      int pick;
      logic lvl;
      @(negedge clock);
      gen_ms    = $urandom_range(0, 1) ? 32'hFFFF_0000 + $urandom_range(0, 65535) : $urandom();
      gen_level = 1'b0;
      push_word(ACT_INIT, gen_level, gen_ms);
      for (int i = 1; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            push_word(ACT_READ, 1'($urandom_range(0, 1)), gen_ms);
         end else if (pick < 11) begin
            push_word(ACT_INIT, gen_level, gen_ms);
         end else if (pick < 13) begin
            push_word(ACT_UNUSED, 1'($urandom_range(0, 1)), $urandom());
         end else begin
            if ($urandom_range(0, 19) == 0) begin
               gen_level = !gen_level;
            end
            if ($urandom_range(0, 49) == 0) begin
               gen_ms = $urandom();
            end else if ($urandom_range(0, 1)) begin
               gen_ms = gen_ms + $urandom_range(0, int'(debounce_ms) / 2 + 1);
            end else begin
               gen_ms = gen_ms + $urandom_range(0, int'(debounce_ms) + int'(long_ms) / 8 + 1);
            end
            lvl = ($urandom_range(0, 4) == 0) ? !gen_level : gen_level;
            push_word(ACT_SAMPLE, lvl, gen_ms);
         end
      end
   endtask

   initial begin : stimulus
      key_stable  = 1'b0;
      key_pressed = 1'b0;
      key_long    = 1'b0;
      agree_ms    = '0;
      press_ms    = '0;
      key_event   = EV_NONE;
      debounce_ms = DEBOUNCE_TIME_RESET;
      long_ms     = LONG_PRESS_TIME_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset timing: bounce rejection, press, long, release, click, wrap
      @(negedge clock);
      push_word(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF);
      push_word(ACT_READ, 1'b0, 32'd0);
      push_word(ACT_INIT, 1'b0, 32'd0);
      push_word(ACT_SAMPLE, 1'b1, 32'd5);
      push_word(ACT_SAMPLE, 1'b0, 32'd6);
      push_word(ACT_SAMPLE, 1'b1, 32'd25);
      push_word(ACT_SAMPLE, 1'b1, 32'd26);
      push_word(ACT_READ, 1'b1, 32'd26);
      push_word(ACT_SAMPLE, 1'b1, 32'd1026);
      push_word(ACT_READ, 1'b1, 32'd1026);
      push_word(ACT_SAMPLE, 1'b0, 32'd1030);
      push_word(ACT_SAMPLE, 1'b0, 32'd1046);
      push_word(ACT_READ, 1'b0, 32'd1046);
      push_word(ACT_SAMPLE, 1'b1, 32'd1100);
      push_word(ACT_SAMPLE, 1'b0, 32'd1130);
      push_word(ACT_READ, 1'b0, 32'd1130);
      push_word(ACT_INIT, 1'b0, 32'hFFFF_FFF0);
      push_word(ACT_SAMPLE, 1'b1, 32'h0000_0004);
      push_word(ACT_READ, 1'b1, 32'h0000_0004);
      wait_drained();

      // zero times: press and long press land in the same sample
      set_timing(16'd0, 16'd0);
      @(negedge clock);
      push_word(ACT_INIT, 1'b0, 32'd1234);
      push_word(ACT_SAMPLE, 1'b1, 32'd1234);
      push_word(ACT_READ, 1'b1, 32'd1234);
      push_word(ACT_SAMPLE, 1'b0, 32'd1234);
      push_word(ACT_READ, 1'b0, 32'd1234);
      wait_drained();

      // full-scale debounce boundary
      set_timing(16'hFFFF, 16'hFFFF);
      @(negedge clock);
      push_word(ACT_INIT, 1'b0, 32'd0);
      push_word(ACT_SAMPLE, 1'b1, 32'd65534);
      push_word(ACT_SAMPLE, 1'b1, 32'd65535);
      wait_drained();

      // random phases; first one backs the result side up
      set_timing(DEBOUNCE_TIME_RESET, LONG_PRESS_TIME_RESET);
      fill_random(PHASE_WORDS);
      hold_asks++;
      wait_drained();

      set_timing(16'd0, 16'd0);
      fill_random(PHASE_WORDS);
      wait_drained();

      set_timing(16'hFFFF, 16'hFFFF);
      fill_random(PHASE_WORDS);
      wait_drained();

      set_timing(16'd1, 16'd1);
      fill_random(PHASE_WORDS);
      wait_drained();

      set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      fill_random(PHASE_WORDS);
      wait_drained();

      // back-to-back stretch with no idling on either side
      set_timing(16'd5, 16'd300);
      no_idle = 1'b1;
      fill_random(PHASE_WORDS);
      wait_drained();
      no_idle = 1'b0;

      repeat (8) @(posedge clock);
      $display("summary: %0d key words sent, %0d results checked", words_sent, results_checked);
      $display("summary: %0d timing settings incl. zero and full-scale times", settings_used);
      if (fail_count == 0 && result_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
